// ----- design/fifo_replacement_cache_macros.svh -----
// ---------------------------------------------------------------------------
// fifo replacement cache assertion macros
// concurrent assertion wrappers, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef FIFO_REPLACEMENT_CACHE_MACROS_SVH
`define FIFO_REPLACEMENT_CACHE_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define FRC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// same-cycle implication
`define FRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FRC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define FRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/frc_pkg.sv -----
// ---------------------------------------------------------------------------
// frc_pkg
// shared types and constants of the fifo replacement cache
// ---------------------------------------------------------------------------
package frc_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int DATA_BITS_DEF = 32;
    localparam int ADDR_W        = 32;
    localparam int DATA_W        = 32;

    // operation codes
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_PUT   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic              returned;
        logic              is_eviction;
        logic [ADDR_W-1:0] ret_addr;
        logic [DATA_W-1:0] ret_data;
        logic              ret_clean;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT_RD,
        ST_EVICT,
        ST_RESULT
    } t_state;

endpackage

// ----- design/fifo_replacement_cache.sv -----
// sequence: an item is scanned slot by slot from the oldest up to the fill count, stopping
//   early on a hit; a write or put that misses in a full cache reads and evicts the oldest entry
// throughput: one item at a time, the next one accepted once the result is registered;
//   the scan rate is one slot per cycle, set by the single read port of the slot memory
// reset: synchronous active low, clears fill count, ring pointers, sequencer and output
//   valid; slot memory keeps its contents and needs no clearing pass
// ---------------------------------------------------------------------------
// fifo_replacement_cache
// fully associative cache with first-in-first-out replacement
// ---------------------------------------------------------------------------
module fifo_replacement_cache #(
    parameter int CAPACITY  = frc_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = frc_pkg::DATA_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  frc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output frc_pkg::t_out_item o_out_item
);
    import frc_pkg::*;

    localparam int WORD_W = (DATA_BITS < 32) ? DATA_BITS : 32;
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // sequencer to slot memory
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0] mem_wkey;
    logic [WORD_W-1:0] mem_wword;
    logic              mem_wclean;
    logic [IDX_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0] mem_rkey;
    logic [WORD_W-1:0] mem_rword;
    logic              mem_rclean;

    // sequencer result toward the output register
    logic              seq_idle;
    logic              res_valid;
    logic              res_take;
    t_out_item         res_item;

    // output register state
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item;

    frc_store #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wkey   (mem_wkey),
        .i_wword  (mem_wword),
        .i_wclean (mem_wclean),
        .i_raddr  (mem_raddr),
        .o_rkey   (mem_rkey),
        .o_rword  (mem_rword),
        .o_rclean (mem_rclean)
    );

    frc_seq #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && seq_idle),
        .i_item      (i_in_item),
        .o_idle      (seq_idle),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wkey      (mem_wkey),
        .o_wword     (mem_wword),
        .o_wclean    (mem_wclean),
        .o_raddr     (mem_raddr),
        .i_rkey      (mem_rkey),
        .i_rword     (mem_rword),
        .i_rclean    (mem_rclean),
        .o_res_valid (res_valid),
        .o_res       (res_item),
        .i_res_take  (res_take)
    );

    // new items enter only while the sequencer is idle; a result waiting in the
    // output register does not hold the input side, but one it cannot take keeps the sequencer busy
    assign o_in_ready = seq_idle;

    // the output register takes a result when empty or emptying this cycle
    assign res_take = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && res_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload register, loaded only on a handoff
    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- design/frc_store.sv -----
// ---------------------------------------------------------------------------
// frc_store
// slot memory: one write port, one registered read port
// ---------------------------------------------------------------------------
module frc_store #(
    parameter int CAPACITY  = frc_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = frc_pkg::DATA_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] i_waddr,
    input  logic [frc_pkg::ADDR_W-1:0]                i_wkey,
    input  logic [(DATA_BITS < 32 ? DATA_BITS : 32)-1:0] i_wword,
    input  logic                                      i_wclean,
    input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] i_raddr,
    output logic [frc_pkg::ADDR_W-1:0]                o_rkey,
    output logic [(DATA_BITS < 32 ? DATA_BITS : 32)-1:0] o_rword,
    output logic                                      o_rclean
);
    import frc_pkg::*;

    localparam int WORD_W = (DATA_BITS < 32) ? DATA_BITS : 32;

    logic [ADDR_W-1:0] r_key_mem   [CAPACITY];
    logic [WORD_W-1:0] r_word_mem  [CAPACITY];
    logic              r_clean_mem [CAPACITY];

    logic [ADDR_W-1:0] r_rkey;
    logic [WORD_W-1:0] r_rword;
    logic              r_rclean;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr]   <= i_wkey;
            r_word_mem[i_waddr]  <= i_wword;
            r_clean_mem[i_waddr] <= i_wclean;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rkey   <= r_key_mem[i_raddr];
        r_rword  <= r_word_mem[i_raddr];
        r_rclean <= r_clean_mem[i_raddr];
    end

    assign o_rkey   = r_rkey;
    assign o_rword  = r_rword;
    assign o_rclean = r_rclean;

endmodule

// ----- design/frc_seq.sv -----
// ---------------------------------------------------------------------------
// frc_seq
// lookup sequencer: walks the valid slots through one key comparator
// ---------------------------------------------------------------------------
`include "fifo_replacement_cache_macros.svh"

module frc_seq #(
    parameter int CAPACITY  = frc_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = frc_pkg::DATA_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  frc_pkg::t_in_item                         i_item,
    output logic                                      o_idle,
    output logic                                      o_we,
    output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] o_waddr,
    output logic [frc_pkg::ADDR_W-1:0]                o_wkey,
    output logic [(DATA_BITS < 32 ? DATA_BITS : 32)-1:0] o_wword,
    output logic                                      o_wclean,
    output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] o_raddr,
    input  logic [frc_pkg::ADDR_W-1:0]                i_rkey,
    input  logic [(DATA_BITS < 32 ? DATA_BITS : 32)-1:0] i_rword,
    input  logic                                      i_rclean,
    output logic                                      o_res_valid,
    output frc_pkg::t_out_item                        o_res,
    input  logic                                      i_res_take
);
    import frc_pkg::*;

    localparam int WORD_W = (DATA_BITS < 32) ? DATA_BITS : 32;
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL    = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

    t_state            r_state, n_state;
    logic [1:0]        r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [WORD_W-1:0] r_word, n_word;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_slot, n_pend_slot;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]  r_oldest, n_oldest;
    logic [IDX_W-1:0]  r_tail, n_tail;
    t_out_item         r_res, n_res;
    logic              match;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
        return (x == LAST_IX) ? '0 : x + IDX_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 1'b0;
            r_fill   <= '0;
            r_oldest <= '0;
            r_tail   <= '0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_fill   <= n_fill;
            r_oldest <= n_oldest;
            r_tail   <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_addr      <= n_addr;
        r_word      <= n_word;
        r_ptr       <= n_ptr;
        r_left      <= n_left;
        r_pend_slot <= n_pend_slot;
        r_res       <= n_res;
    end

    // the shared comparator
    assign match = r_pend && (i_rkey == r_addr);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_word      = r_word;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_tail      = r_tail;
        n_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = r_tail;
        o_wkey      = r_addr;
        o_wword     = r_word;
        o_wclean    = (r_kind == KIND_PUT);
        o_raddr     = (r_state == ST_EVICT_RD) ? r_oldest : r_ptr;
        o_res_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_kind = i_item.kind;
                    n_addr = i_item.addr;
                    n_word = i_item.data_in[WORD_W-1:0];
                    n_ptr  = r_oldest;
                    n_left = r_fill;
                    n_pend = 1'b0;
                    n_res  = '0;
                    if (i_item.kind inside {KIND_READ, KIND_WRITE, KIND_PUT}) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_pend  = 1'b0;
                    n_state = ST_RESULT;
                    case (r_kind)
                        KIND_READ: begin
                            n_res = '{returned: 1'b1, is_eviction: 1'b0, ret_addr: r_addr,
                                      ret_data: DATA_W'(i_rword), ret_clean: i_rclean};
                        end
                        KIND_WRITE: begin
                            o_we     = 1'b1;
                            o_waddr  = r_pend_slot;
                            o_wclean = 1'b0;
                            n_res = '{returned: 1'b1, is_eviction: 1'b0, ret_addr: r_addr,
                                      ret_data: DATA_W'(r_word), ret_clean: 1'b0};
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end else if (r_left != '0) begin
                    // issue the next slot read, compare it next cycle
                    n_pend      = 1'b1;
                    n_pend_slot = r_ptr;
                    n_ptr       = wrap_inc(r_ptr);
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                    n_res  = '0;
                    if (r_kind == KIND_WRITE || r_kind == KIND_PUT) begin
                        if (r_fill != FULL) begin
                            o_we    = 1'b1;
                            o_waddr = r_tail;
                            n_fill  = r_fill + CNT_W'(1);
                            n_tail  = wrap_inc(r_tail);
                            n_state = ST_RESULT;
                        end else begin
                            n_state = ST_EVICT_RD;
                        end
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_EVICT_RD: begin
                n_state = ST_EVICT;
            end
            ST_EVICT: begin
                n_res = '{returned: 1'b1, is_eviction: 1'b1, ret_addr: i_rkey,
                          ret_data: DATA_W'(i_rword), ret_clean: i_rclean};
                o_we     = 1'b1;
                o_waddr  = r_oldest;
                n_oldest = wrap_inc(r_oldest);
                n_tail   = wrap_inc(r_tail);
                n_state  = ST_RESULT;
            end
            ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_res  = r_res;

    `FRC_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FULL, "fill count above capacity")
    `FRC_ASSERT_IMP(a_evict_full, i_clk, i_rst_n, r_state == ST_EVICT, r_fill == FULL, "eviction while not full")
    `FRC_ASSERT_IMP(a_ring_ptrs, i_clk, i_rst_n, r_fill != '0 && r_fill != FULL, r_oldest != r_tail, "ring pointers meet while partly filled")
    `FRC_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && o_idle, !o_idle, "sequencer idle right after an item")

endmodule
